>>> rtl/lcw_pkg.sv
// lcw_pkg: shared types, constants and fixed-point helpers for the lorenz waveshaper
// no dependencies
package lcw_pkg;

  typedef enum logic [2:0] {
    REG_STEP    = 3'd0,
    REG_SIGMA   = 3'd1,
    REG_RHO     = 3'd2,
    REG_BETA    = 3'd3,
    REG_START_X = 3'd4,
    REG_START_Y = 3'd5,
    REG_START_Z = 3'd6
  } reg_index_t;

  typedef enum logic [5:0] {
    S_IDLE, S_HS, S_XA, S_XB, S_YA, S_YB, S_ZA, S_ZB, S_ZC,
    S_SQX, S_SQY, S_SQZ, S_SQF, S_SQD, S_ROOT, S_PH, S_MOD, S_FOLD,
    S_T2, S_K1, S_K2, S_K3, S_K4, S_SIN, S_RES, S_U, S_UW, S_OUT
  } st_t;

  localparam logic signed [31:0] RST_STEP  = 32'sd16777;
  localparam logic signed [31:0] RST_SIGMA = 32'sd167772160;
  localparam logic signed [31:0] RST_RHO   = 32'sd469762048;
  localparam logic signed [31:0] RST_BETA  = 32'sd44739243;
  localparam logic signed [31:0] RST_X     = 32'sd1677722;
  localparam logic signed [31:0] RST_Y     = 32'sd0;
  localparam logic signed [31:0] RST_Z     = 32'sd0;

  localparam logic [32:0] K_Q24          = 33'd580450;
  localparam logic [33:0] TWO_PI_Q30     = 34'd6746518852;
  localparam logic [33:0] PI_Q30         = 34'd3373259426;
  localparam logic [33:0] HALF_PI_Q30    = 34'd1686629713;
  localparam logic [33:0] QUARTER_PI_Q30 = 34'd843314857;
  localparam logic [30:0] ONE_Q30        = 31'd1073741824;
  localparam logic [2:0]  LAST_TERM      = 3'd4;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh80000000 : 32'sh7fffffff;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32({a[31], a} + {b[31], b});
  endfunction

  function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32({a[31], a} - {b[31], b});
  endfunction

  // product of two q8.24 values, floor to q8.24, saturate
  function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
    if ((&p[65:55]) || !(|p[65:55])) begin
      return p[55:24];
    end
    return p[65] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  // series divisors, cosine kernel then sine kernel
  function automatic logic [6:0] term_div(input logic use_sin, input logic [2:0] i);
    logic [6:0] n;
    case (i)
      3'd0:    n = use_sin ? 7'd110 : 7'd90;
      3'd1:    n = use_sin ? 7'd72  : 7'd56;
      3'd2:    n = use_sin ? 7'd42  : 7'd30;
      3'd3:    n = use_sin ? 7'd20  : 7'd12;
      default: n = use_sin ? 7'd6   : 7'd2;
    endcase
    return n;
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] term_recip(input logic use_sin, input logic [2:0] i);
    logic [31:0] m;
    case (i)
      3'd0:    m = use_sin ? 32'd39045157  : 32'd47721858;
      3'd1:    m = use_sin ? 32'd59652323  : 32'd76695844;
      3'd2:    m = use_sin ? 32'd102261126 : 32'd143165576;
      3'd3:    m = use_sin ? 32'd214748364 : 32'd357913941;
      default: m = use_sin ? 32'd715827882 : 32'd2147483648;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/lcw_mul.sv
// lcw_mul: shared 33x33 signed multiplier with registered product
// uses no package items
module lcw_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/lcw_isqrt.sv
// lcw_isqrt: floor square root of a 64-bit value, one root bit per cycle
// uses no package items
module lcw_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] val;
  logic [32:0] rem;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  assign rem_sh = {rem, val[63:62]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val <= {val[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= 33'(rem_sh - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh[32:0];
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/lorenz_chaos_waveshaper_core.sv
// lorenz_chaos_waveshaper_core: top level, sequencer and state of the waveshaper
// depends on lcw_pkg, lcw_mul and lcw_isqrt
//
// Each input item advances a Lorenz system one Euler step and returns one
// shaped cosine sample. Work for one item runs on a single shared multiplier
// and a bit-serial square root unit: the Euler step, the sum of squares,
// then two shaping passes of square root, phase reduction and series
// evaluation each, and last the load of the output register. in_stall is
// high while an item is in progress; a finished item waits in the output
// register while the next one is taken. Configuration should be written
// only while no item is in flight; writing a start register reloads that
// coordinate.
module lorenz_chaos_waveshaper_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] sample_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] wave_out
);
  import lcw_pkg::*;

  st_t state, state_next;

  logic signed [31:0] step_size, coef_sigma, coef_rho, coef_beta;
  logic signed [31:0] start_x, start_y, start_z;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] x1, y1, z1, dz;
  logic signed [27:0] f;
  logic [63:0]        sum;
  logic [55:0]        ff;
  logic signed [37:0] ang;
  logic               neg, use_sin, pass;
  logic [29:0]        t, t2, v, q0;
  logic [30:0]        acc;
  logic [2:0]         idx;
  logic [24:0]        umag;
  logic signed [17:0] ores;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p;
  logic               sq_start, sq_done;
  logic [63:0]        sq_value;
  logic [31:0]        sq_root;

  logic signed [31:0] qp;
  logic signed [30:0] ph_c;
  logic [33:0]        a0, a1, a2;
  logic               neg_c, sin_c;
  logic [29:0]        t_c;
  logic [30:0]        rem_c, res_c;
  logic [31:0]        ur_c, or_c;
  logic [16:0]        omag_c;

  lcw_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  lcw_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(sq_value),
    .done(sq_done), .root(sq_root)
  );

  assign qp       = qsat(p);
  assign in_stall = (state != S_IDLE);

  assign ph_c = $signed({1'b0, p[53:24]}) - 31'sd16777216;

  // phase folding to [0, pi/4]
  assign a0    = ang[33:0];
  assign a1    = (a0 > PI_Q30) ? 34'(TWO_PI_Q30 - a0) : a0;
  assign neg_c = (a1 > HALF_PI_Q30);
  assign a2    = neg_c ? 34'(PI_Q30 - a1) : a1;
  assign sin_c = (a2 > QUARTER_PI_Q30);
  assign t_c   = sin_c ? 30'(HALF_PI_Q30 - a2) : a2[29:0];

  assign rem_c  = {1'b0, v} - p[30:0];
  assign res_c  = use_sin ? p[60:30] : acc;
  assign ur_c   = {1'b0, res_c} + 32'd32;
  assign or_c   = {1'b0, res_c} + 32'd8192;
  assign omag_c = (or_c[31:14] > 18'd65536) ? 17'd65536 : or_c[30:14];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    sq_start   = 1'b0;
    sq_value   = sum + p[63:0];
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_HS;
      end
      S_HS: begin
        mul_a = {step_size[31], step_size};
        mul_b = {coef_sigma[31], coef_sigma};
        state_next = S_XA;
      end
      S_XA: begin
        mul_a = {qp[31], qp};
        mul_b = 33'(ssub(pos_y, pos_x));
        state_next = S_XB;
      end
      S_XB: begin
        mul_a = {pos_x[31], pos_x};
        mul_b = 33'(ssub(coef_rho, pos_z));
        state_next = S_YA;
      end
      S_YA: begin
        mul_a = {step_size[31], step_size};
        mul_b = 33'(ssub(qp, pos_y));
        state_next = S_YB;
      end
      S_YB: begin
        mul_a = {pos_x[31], pos_x};
        mul_b = {pos_y[31], pos_y};
        state_next = S_ZA;
      end
      S_ZA: begin
        mul_a = {coef_beta[31], coef_beta};
        mul_b = {pos_z[31], pos_z};
        state_next = S_ZB;
      end
      S_ZB: begin
        mul_a = {step_size[31], step_size};
        mul_b = 33'(ssub(dz, qp));
        state_next = S_ZC;
      end
      S_ZC: state_next = S_SQX;
      S_SQX: begin
        mul_a = {x1[31], x1};
        mul_b = {x1[31], x1};
        state_next = S_SQY;
      end
      S_SQY: begin
        mul_a = {y1[31], y1};
        mul_b = {y1[31], y1};
        state_next = S_SQZ;
      end
      S_SQZ: begin
        mul_a = {z1[31], z1};
        mul_b = {z1[31], z1};
        state_next = S_SQF;
      end
      S_SQF: begin
        mul_a = 33'(f);
        mul_b = 33'(f);
        state_next = S_SQD;
      end
      S_SQD: begin
        sq_start   = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        mul_a = {1'b0, sq_root};
        mul_b = K_Q24;
        if (sq_done) state_next = S_PH;
      end
      S_PH: state_next = S_MOD;
      S_MOD: begin
        if (!ang[37] && ang < $signed({4'b0, TWO_PI_Q30})) state_next = S_FOLD;
      end
      S_FOLD: begin
        mul_a = {3'b0, t_c};
        mul_b = {3'b0, t_c};
        state_next = S_T2;
      end
      S_T2: state_next = S_K1;
      S_K1: begin
        mul_a = {3'b0, t2};
        mul_b = {2'b0, acc};
        state_next = S_K2;
      end
      S_K2: begin
        mul_a = {3'b0, p[59:30]};
        mul_b = {1'b0, term_recip(use_sin, idx)};
        state_next = S_K3;
      end
      S_K3: begin
        mul_a = {3'b0, p[61:32]};
        mul_b = {26'b0, term_div(use_sin, idx)};
        state_next = S_K4;
      end
      S_K4: begin
        if (idx != LAST_TERM) state_next = S_K1;
        else if (use_sin) state_next = S_SIN;
        else state_next = S_RES;
      end
      S_SIN: begin
        mul_a = {3'b0, t};
        mul_b = {2'b0, acc};
        state_next = S_RES;
      end
      S_RES: state_next = pass ? S_OUT : S_U;
      S_U: begin
        mul_a = {8'b0, umag};
        mul_b = {8'b0, umag};
        state_next = S_UW;
      end
      S_UW: begin
        sq_start   = 1'b1;
        sq_value   = {8'b0, ff} + p[63:0];
        state_next = S_ROOT;
      end
      S_OUT: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration and lorenz state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= RST_STEP;
      coef_sigma <= RST_SIGMA;
      coef_rho   <= RST_RHO;
      coef_beta  <= RST_BETA;
      start_x    <= RST_X;
      start_y    <= RST_Y;
      start_z    <= RST_Z;
      pos_x      <= RST_X;
      pos_y      <= RST_Y;
      pos_z      <= RST_Z;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_STEP:  step_size  <= cfg_data;
          REG_SIGMA: coef_sigma <= cfg_data;
          REG_RHO:   coef_rho   <= cfg_data;
          REG_BETA:  coef_beta  <= cfg_data;
          REG_START_X: begin
            start_x <= cfg_data;
            pos_x   <= cfg_data;
          end
          REG_START_Y: begin
            start_y <= cfg_data;
            pos_y   <= cfg_data;
          end
          REG_START_Z: begin
            start_z <= cfg_data;
            pos_z   <= cfg_data;
          end
          default: ;
        endcase
      end
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        pos_x <= x1;
        pos_y <= y1;
        pos_z <= z1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      wave_out <= ores;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        f    <= {sample_in, 4'b0};
        pass <= 1'b0;
      end
      S_XB: x1 <= sadd(pos_x, qp);
      S_YB: y1 <= sadd(pos_y, qp);
      S_ZA: dz <= qp;
      S_ZC: z1 <= sadd(pos_z, qp);
      S_SQY: sum <= p[63:0];
      S_SQZ: sum <= sum + p[63:0];
      S_SQF: sum <= sum + p[63:0];
      S_SQD: ff <= p[55:0];
      S_PH: ang <= {ph_c[30], ph_c, 6'b0};
      S_MOD: begin
        if (ang[37]) ang <= ang + $signed({4'b0, TWO_PI_Q30});
        else if (ang >= $signed({4'b0, TWO_PI_Q30})) ang <= ang - $signed({4'b0, TWO_PI_Q30});
      end
      S_FOLD: begin
        t       <= t_c;
        neg     <= neg_c;
        use_sin <= sin_c;
      end
      S_T2: begin
        t2  <= p[59:30];
        acc <= ONE_Q30;
        idx <= '0;
      end
      S_K2: v <= p[59:30];
      S_K3: q0 <= p[61:32];
      S_K4: begin
        if (rem_c >= {24'b0, term_div(use_sin, idx)}) acc <= ONE_Q30 - 31'({1'b0, q0} + 31'd1);
        else acc <= ONE_Q30 - {1'b0, q0};
        idx <= idx + 3'd1;
      end
      S_RES: begin
        if (!pass) begin
          umag <= ur_c[30:6];
        end else begin
          ores <= neg ? -$signed({1'b0, omag_c}) : $signed({1'b0, omag_c});
        end
      end
      S_UW: pass <= 1'b1;
      default: ;
    endcase
  end

endmodule

>>> rtl/lcw_checker.sv
// lcw_checker: port-level checks on the waveshaper, bound to the top level
// depends on lorenz_chaos_waveshaper_core port names
module lcw_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [17:0] wave_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(wave_out))
    else $error("stalled item changed");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wave_out <= 18'sd65536) && (wave_out >= -18'sd65536))
    else $error("output out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after accept");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("item produced without work");

endmodule

bind lorenz_chaos_waveshaper_core lcw_checker u_lcw_checker (.*);

>>> dv/testbench.sv
// testbench: self-checking bench for lorenz_chaos_waveshaper_core
// holds a bit-exact predictor of the euler step and shaped cosine chain
// depends on rtl/lcw_pkg.sv and rtl/lorenz_chaos_waveshaper_core.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lcw_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint ONE30 = 64'sd1073741824;
  localparam longint TWO_PI30 = 64'sd6746518852;
  localparam longint PI30 = 64'sd3373259426;
  localparam longint HALF_PI30 = 64'sd1686629713;
  localparam longint QUARTER_PI30 = 64'sd843314857;
  localparam longint K24 = 64'sd580450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_STEP;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [17:0] wave_out;

  lorenz_chaos_waveshaper_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .wave_out(wave_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and configuration
  int h_cfg, sigma_cfg, rho_cfg, beta_cfg, sx_cfg, sy_cfg, sz_cfg;
  int trk_x, trk_y, trk_z;
  logic signed [17:0] wave_expect[$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  int stall_pct = 0;
  int gap_max = 0;
  int hold_req = 0;

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int qmul(int a, int b);
    return clamp32((longint'(a) * longint'(b)) >>> 24);
  endfunction

  function automatic longint round_mag(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint series_eval(longint t, bit use_sin);
    longint cdiv[5] = '{90, 56, 30, 12, 2};
    longint sdiv[5] = '{110, 72, 42, 20, 6};
    longint t2, acc;
    t2 = (t * t) >>> 30;
    acc = ONE30;
    for (int i = 0; i < 5; i++)
      acc = ONE30 - ((t2 * acc) >>> 30) / (use_sin ? sdiv[i] : cdiv[i]);
    return use_sin ? ((t * acc) >>> 30) : acc;
  endfunction

  // cos(k*sqrt(sum) - 1) in q30
  function automatic longint shaped_cos(longint unsigned sum48);
    longint ph, a, r;
    bit neg;
    neg = 0;
    ph = longint'((int_sqrt(sum48) * K24) >> 24) - 64'sd16777216;
    a = (ph * 64) % TWO_PI30;
    if (a < 0) a = a + TWO_PI30;
    if (a > PI30) a = TWO_PI30 - a;
    if (a > HALF_PI30) begin
      a = PI30 - a;
      neg = 1;
    end
    if (a > QUARTER_PI30) r = series_eval(HALF_PI30 - a, 1);
    else r = series_eval(a, 0);
    return neg ? -r : r;
  endfunction

  function automatic logic signed [17:0] lorenz_shape(logic signed [23:0] s);
    longint f, u30, u24, o;
    longint unsigned sum;
    int x0, y0, z0, x1, y1, z1, t;
    f = longint'(s) * 16;
    x0 = trk_x;
    y0 = trk_y;
    z0 = trk_z;
    t = qmul(qmul(h_cfg, sigma_cfg), clamp32(longint'(y0) - longint'(x0)));
    x1 = clamp32(longint'(x0) + longint'(t));
    t = clamp32(longint'(qmul(x0, clamp32(longint'(rho_cfg) - longint'(z0)))) - longint'(y0));
    y1 = clamp32(longint'(y0) + longint'(qmul(h_cfg, t)));
    t = clamp32(longint'(qmul(x0, y0)) - longint'(qmul(beta_cfg, z0)));
    z1 = clamp32(longint'(z0) + longint'(qmul(h_cfg, t)));
    sum = longint'(x1) * longint'(x1) + longint'(y1) * longint'(y1)
        + longint'(z1) * longint'(z1) + f * f;
    u30 = shaped_cos(sum);
    u24 = round_mag(u30, 6);
    o = round_mag(shaped_cos(f * f + u24 * u24), 14);
    if (o > 65536) o = 65536;
    if (o < -65536) o = -65536;
    trk_x = x1;
    trk_y = y1;
    trk_z = z1;
    return o[17:0];
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, wave_expect.size());
      $display("lorenz_chaos_waveshaper_core verification failed");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      out_stall = 1'b1;
      hold_req = hold_req - 1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (wave_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item wave_out=%0d", wave_out);
      end else begin
        logic signed [17:0] want;
        want = wave_expect.pop_front();
        if (wave_out !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("wave_out mismatch: expected %0d got %0d", want, wave_out);
        end
      end
    end
  end

  task automatic drain();
    @(posedge clk);
    while (wave_expect.size() != 0 || in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_STEP:    h_cfg = val;
      REG_SIGMA:   sigma_cfg = val;
      REG_RHO:     rho_cfg = val;
      REG_BETA:    beta_cfg = val;
      REG_START_X: begin sx_cfg = val; trk_x = val; end
      REG_START_Y: begin sy_cfg = val; trk_y = val; end
      REG_START_Z: begin sz_cfg = val; trk_z = val; end
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // called at a falling edge; leaves at a falling edge with in_valid still set
  task automatic send_sample(logic signed [23:0] s);
    in_valid = 1'b1;
    sample_in = s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    wave_expect.push_back(lorenz_shape(s));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    int burst;
    burst = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      logic signed [23:0] s;
      case ($urandom_range(3))
        0: s = 24'($urandom_range(2047) - 1024);
        1: s = $urandom_range(1, 3) == 1 ? 24'(24'sh7fffff - $urandom_range(255)) :
                                            24'(24'sh800000 + $urandom_range(255));
        default: s = 24'($urandom);
      endcase
      send_sample(s);
      burst--;
      if (burst == 0) begin
        int gap;
        gap = $urandom_range(gap_max);
        if (gap != 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 6);
      end
    end
    in_valid = 1'b0;
  endtask

  task automatic test_reset_values();
    logic signed [23:0] dirs[8] = '{24'sd0, 24'sh7fffff, 24'sh800000, 24'sd1, -24'sd1,
                                   24'sh400000, -24'sh400000, 24'sh555555};
    stall_pct = 0;
    foreach (dirs[i]) send_sample(dirs[i]);
    in_valid = 1'b0;
  endtask

  task automatic test_register_extremes();
    write_reg(REG_UNUSED, 32'h1234_5678);
    send_sample(24'sd100);
    in_valid = 1'b0;
    write_reg(REG_STEP, 32'sh7fffffff);
    write_reg(REG_SIGMA, 32'sh80000000);
    write_reg(REG_RHO, 32'sh7fffffff);
    write_reg(REG_BETA, 32'sh80000000);
    write_reg(REG_START_X, 32'sh7fffffff);
    write_reg(REG_START_Y, 32'sh80000000);
    write_reg(REG_START_Z, 32'sh7fffffff);
    send_sample(24'sh7fffff);
    send_sample(24'sh800000);
    send_sample(24'sd0);
    in_valid = 1'b0;
    write_reg(REG_STEP, 32'sh80000000);
    write_reg(REG_SIGMA, 32'sh7fffffff);
    write_reg(REG_RHO, 32'sh80000000);
    write_reg(REG_BETA, 32'sh7fffffff);
    write_reg(REG_START_X, 32'sh80000000);
    write_reg(REG_START_Y, 32'sh7fffffff);
    write_reg(REG_START_Z, 32'sh80000000);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    send_sample(24'sd0);
    in_valid = 1'b0;
    write_reg(REG_STEP, 0);
    write_reg(REG_START_X, 0);
    write_reg(REG_START_Y, 0);
    write_reg(REG_START_Z, 0);
    send_sample(24'sd0);
    send_sample(24'sh7fffff);
    in_valid = 1'b0;
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 10; p++) begin
      if (p % 3 == 2) begin
        write_reg(REG_STEP, $urandom);
        write_reg(REG_SIGMA, $urandom);
        write_reg(REG_RHO, $urandom);
        write_reg(REG_BETA, $urandom);
        write_reg(REG_START_X, $urandom);
        write_reg(REG_START_Y, $urandom);
        write_reg(REG_START_Z, $urandom);
      end else begin
        write_reg(REG_STEP, $urandom_range(400000));
        write_reg(REG_SIGMA, RST_SIGMA + $urandom_range(33554432) - 16777216);
        write_reg(REG_RHO, RST_RHO + $urandom_range(67108864) - 33554432);
        write_reg(REG_BETA, RST_BETA + $urandom_range(8388608) - 4194304);
        if (p % 3 == 0) begin
          write_reg(REG_START_X, $urandom_range(33554432) - 16777216);
          write_reg(REG_START_Y, $urandom_range(33554432) - 16777216);
          write_reg(REG_START_Z, $urandom_range(33554432));
        end
      end
      stall_pct = (p % 4 == 0) ? 0 : $urandom_range(10, 70);
      gap_max = (p % 4 == 1) ? 0 : $urandom_range(1, 10);
      send_random(55);
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 1500;
    stall_pct = 0;
    gap_max = 0;
    send_random(8);
    send_random(10);
    drain();
    send_random(10);
  endtask

  initial begin
    h_cfg = RST_STEP;
    sigma_cfg = RST_SIGMA;
    rho_cfg = RST_RHO;
    beta_cfg = RST_BETA;
    sx_cfg = RST_X;
    sy_cfg = RST_Y;
    sz_cfg = RST_Z;
    trk_x = RST_X;
    trk_y = RST_Y;
    trk_z = RST_Z;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_reset_values();
    test_register_extremes();
    test_random_settings();
    test_backpressure();
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d items, %0d results, reset and extreme register settings,",
             items_sent, results_seen);
    $display("ten random settings, start reloads and a long output hold-off");
    if (mismatches == 0 && wave_expect.size() == 0) begin
      $display("lorenz_chaos_waveshaper_core verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, wave_expect.size());
      $display("lorenz_chaos_waveshaper_core verification failed");
    end
    $finish;
  end
endmodule
